// File: rtl/lam_pkg.sv
`timescale 1ns / 1ps

package lam_pkg;

  localparam int SampleW = 16;
  localparam int AlarmW  = 5;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  // Status / enable bit positions
  localparam int BitOverVolt  = 0;
  localparam int BitUnderVolt = 1;
  localparam int BitOverCurr  = 2;
  localparam int BitOverTemp  = 3;
  localparam int BitInPos     = 4;

  // In-position window, plus or minus this many counts
  localparam int PosWindow = 2;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegVoltMax     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegVoltMin     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTempMax     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCurrMax     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAlarmEnable = 3'd4;
  localparam logic [CfgIdxW-1:0] RegIrqMask     = 3'd5;

  localparam logic [AlarmW-1:0] MaskAll = '1;

  typedef struct packed {
    logic [SampleW-1:0] volt_max;
    logic [SampleW-1:0] volt_min;
    logic [SampleW-1:0] temp_max;
    logic [SampleW-1:0] curr_max;
    logic [AlarmW-1:0]  alarm_enable;
    logic [AlarmW-1:0]  irq_mask;
  } cfg_t;

  typedef struct packed {
    logic [SampleW-1:0]        voltage;
    logic [SampleW-1:0]        current;
    logic [SampleW-1:0]        temperature;
    logic [SampleW-1:0]        position;
    logic [SampleW-1:0]        target;
    logic signed [SampleW-1:0] drive_in;
    logic [AlarmW-1:0]         clear_mask;
  } item_t;

  typedef struct packed {
    logic [AlarmW-1:0]  alarm_bits;
    logic [SampleW-1:0] throttle;
    logic               irq_level;
  } state_t;

  typedef struct packed {
    logic [AlarmW-1:0]         status;
    logic                      irq_line;
    logic signed [SampleW-1:0] drive_out;
    logic                      drive_off;
  } res_t;

  typedef struct packed {
    state_t nxt;
    res_t   res;
    logic   checked;   // tick was not skipped
    logic   thr_load;  // over-current reloaded the throttle
  } chk_t;

endpackage

// File: rtl/lam_if.sv
`timescale 1ns / 1ps

interface lam_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [lam_pkg::SampleW-1:0]          voltage;
  logic [lam_pkg::SampleW-1:0]          current;
  logic [lam_pkg::SampleW-1:0]          temperature;
  logic [lam_pkg::SampleW-1:0]          position;
  logic [lam_pkg::SampleW-1:0]          target;
  logic signed [lam_pkg::SampleW-1:0]   drive_in;
  logic [lam_pkg::AlarmW-1:0]           clear_mask;

  modport source (output valid, voltage, current, temperature, position, target,
                  drive_in, clear_mask, input ready);
  modport sink (input valid, voltage, current, temperature, position, target,
                drive_in, clear_mask, output ready);
endinterface

interface lam_out_if;
  logic                               valid;
  logic                               ready;
  logic [lam_pkg::AlarmW-1:0]         status;
  logic                               irq_line;
  logic signed [lam_pkg::SampleW-1:0] drive_out;
  logic                               drive_off;

  modport source (output valid, status, irq_line, drive_out, drive_off, input ready);
  modport sink (input valid, status, irq_line, drive_out, drive_off, output ready);
endinterface

// File: rtl/limit_alarm_monitor.sv
`timescale 1ns / 1ps

// Limit alarm monitor. Each sample word (voltage, current, temperature,
// position, target, signed drive and a host clear mask) yields exactly one
// result word: sticky alarm status, interrupt line level, throttled drive and
// a drive-off pulse. Status bits: 0 over-voltage, 1 under-voltage,
// 2 over-current, 3 over-temperature, 4 in-position (position within +/-2 of
// target). A zero limit disables its check. Over-current loads a throttle
// with the excess current, which then fades by one per checked sample; the
// drive moves toward zero by twice the throttle held before the sample.
// Rate: one sample per clock, sustained while result words are taken. A
// sample is held in the input register and is evaluated in one pass of
// comparators and one add/subtract into the result register, where its
// result word is held until taken. A full result register that is not
// taken holds the pipeline; an empty input register still takes one more
// word. Configuration writes take effect at any edge with cfg_we high, so
// write them only while no sample is in flight.
module limit_alarm_monitor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lam_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [lam_pkg::CfgDataW-1:0] cfg_data,
  lam_in_if.sink                       sample,
  lam_out_if.source                    result
);

  lam_pkg::cfg_t   cfg;
  lam_pkg::item_t  in_item;
  lam_pkg::state_t st;
  lam_pkg::chk_t   chk;
  lam_pkg::res_t   out_res;
  logic            in_vld;
  logic            out_vld;
  logic            fire;

  lam_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Evaluate when a word is held and the result register is free or draining
  assign fire         = in_vld && (!out_vld || result.ready);
  assign sample.ready = !in_vld || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (sample.ready) begin
      in_vld <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_item.voltage     <= sample.voltage;
      in_item.current     <= sample.current;
      in_item.temperature <= sample.temperature;
      in_item.position    <= sample.position;
      in_item.target      <= sample.target;
      in_item.drive_in    <= sample.drive_in;
      in_item.clear_mask  <= sample.clear_mask;
    end
  end

  lam_check u_check (
    .cfg  (cfg),
    .item (in_item),
    .st   (st),
    .chk  (chk)
  );

  // Sticky alarm bits, throttle and line level advance once per evaluated word
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= chk.nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fire) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= chk.res;
    end
  end

  assign result.valid     = out_vld;
  assign result.status    = out_res.status;
  assign result.irq_line  = out_res.irq_line;
  assign result.drive_out = out_res.drive_out;
  assign result.drive_off = out_res.drive_off;

  // A drive-off pulse always comes with the over-temperature bit
  a_off_has_temp: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_res.drive_off |-> out_res.status[lam_pkg::BitOverTemp])
    else $error("drive_off without over-temperature status");

  // The line can only be high while some alarm bit is set
  a_irq_needs_bits: assert property (@(posedge clk) disable iff (rst)
    st.irq_level |-> (st.alarm_bits != '0))
    else $error("interrupt level high with no alarm bits");

  // Without a reload, a checked word fades a nonzero throttle by one
  a_thr_fade: assert property (@(posedge clk) disable iff (rst)
    fire && chk.checked && !chk.thr_load && (st.throttle != '0)
    |=> st.throttle == $past(st.throttle) - lam_pkg::SampleW'(1))
    else $error("throttle did not fade by one");

  // Nothing is evaluated without a held input word
  a_fire_needs_word: assert property (@(posedge clk) disable iff (rst)
    !in_vld |=> $stable(st))
    else $error("state changed with no word held");

endmodule

// File: rtl/lam_cfg.sv
`timescale 1ns / 1ps

module lam_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lam_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [lam_pkg::CfgDataW-1:0]    cfg_data,
  output lam_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volt_max     <= '0;
      cfg.volt_min     <= '0;
      cfg.temp_max     <= '0;
      cfg.curr_max     <= '0;
      cfg.alarm_enable <= lam_pkg::MaskAll;
      cfg.irq_mask     <= lam_pkg::MaskAll;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lam_pkg::RegVoltMax:     cfg.volt_max <= cfg_data;
        lam_pkg::RegVoltMin:     cfg.volt_min <= cfg_data;
        lam_pkg::RegTempMax:     cfg.temp_max <= cfg_data;
        lam_pkg::RegCurrMax:     cfg.curr_max <= cfg_data;
        lam_pkg::RegAlarmEnable: cfg.alarm_enable <= cfg_data[lam_pkg::AlarmW-1:0];
        lam_pkg::RegIrqMask:     cfg.irq_mask <= cfg_data[lam_pkg::AlarmW-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

endmodule

// File: rtl/lam_check.sv
`timescale 1ns / 1ps

module lam_check (
  input  lam_pkg::cfg_t   cfg,
  input  lam_pkg::item_t  item,
  input  lam_pkg::state_t st,
  output lam_pkg::chk_t   chk
);

  localparam int W = lam_pkg::SampleW;

  logic                 active;
  logic                 ov, uv, oc, ot, inpos;
  logic signed [W:0]    diff;
  logic [lam_pkg::AlarmW-1:0] bits_clr, bits_chk;
  logic [W-1:0]         thr_mid;
  logic signed [W+1:0]  d_ext, cut_ext, d_sum;
  logic signed [W-1:0]  drive;

  always_comb begin
    active = !((cfg.alarm_enable == '0) && !st.irq_level);
    bits_clr = st.alarm_bits & ~item.clear_mask;

    ov = cfg.alarm_enable[lam_pkg::BitOverVolt] && (cfg.volt_max != '0)
         && (item.voltage > cfg.volt_max);
    uv = cfg.alarm_enable[lam_pkg::BitOverVolt] && !ov && (cfg.volt_min != '0)
         && (item.voltage < cfg.volt_min);
    oc = cfg.alarm_enable[lam_pkg::BitOverCurr] && (cfg.curr_max != '0)
         && (item.current > cfg.curr_max);
    ot = cfg.alarm_enable[lam_pkg::BitOverTemp] && (cfg.temp_max != '0)
         && (item.temperature > cfg.temp_max);

    diff  = $signed({1'b0, item.position}) - $signed({1'b0, item.target});
    inpos = cfg.alarm_enable[lam_pkg::BitInPos]
            && (diff >= -(W+1)'(lam_pkg::PosWindow))
            && (diff <= (W+1)'(lam_pkg::PosWindow));

    bits_chk = bits_clr;
    bits_chk[lam_pkg::BitOverVolt]  = bits_clr[lam_pkg::BitOverVolt] | ov;
    bits_chk[lam_pkg::BitUnderVolt] = bits_clr[lam_pkg::BitUnderVolt] | uv;
    bits_chk[lam_pkg::BitOverCurr]  = bits_clr[lam_pkg::BitOverCurr] | oc;
    bits_chk[lam_pkg::BitOverTemp]  = bits_clr[lam_pkg::BitOverTemp] | ot;
    bits_chk[lam_pkg::BitInPos]     = inpos;

    thr_mid = oc ? (item.current - cfg.curr_max) : st.throttle;

    // Move drive toward zero by twice the starting throttle, stop at zero
    d_ext   = (W+2)'(item.drive_in);
    cut_ext = $signed({1'b0, st.throttle, 1'b0});
    if (item.drive_in > 0) begin
      d_sum = d_ext - cut_ext;
      drive = (d_sum < 0) ? '0 : d_sum[W-1:0];
    end else if (item.drive_in < 0) begin
      d_sum = d_ext + cut_ext;
      drive = (d_sum > 0) ? '0 : d_sum[W-1:0];
    end else begin
      d_sum = d_ext;
      drive = '0;
    end

    if (active) begin
      chk.nxt.alarm_bits = bits_chk;
      chk.nxt.irq_level  = (inpos || st.irq_level) && ((bits_chk & cfg.irq_mask) != '0);
      chk.nxt.throttle   = (thr_mid != '0) ? thr_mid - W'(1) : thr_mid;
      chk.res.drive_off  = ot;
    end else begin
      chk.nxt.alarm_bits = bits_clr;
      chk.nxt.irq_level  = st.irq_level;
      chk.nxt.throttle   = st.throttle;
      chk.res.drive_off  = 1'b0;
    end

    chk.res.status    = chk.nxt.alarm_bits;
    chk.res.irq_line  = chk.nxt.irq_level;
    chk.res.drive_out = drive;
    chk.checked       = active;
    chk.thr_load      = active && oc;
  end

endmodule

// File: tb/lam_result_checker.sv
`timescale 1ns / 1ps

module lam_result_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lam_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [lam_pkg::CfgDataW-1:0] cfg_data,
  lam_in_if                            sample,
  lam_out_if                           result,
  output int                           mismatches,
  output int                           awaiting
);
  import lam_pkg::*;

  cfg_t   limits;
  state_t mon;
  res_t   due_results[$];
  int     err_cnt;

  // Evaluate one sample word against the limits and advance the alarm state.
  function automatic res_t next_alarm_result(item_t w);
    res_t              r;
    logic [SampleW-1:0] thr_start;
    int                gap;
    int                lvl;
    int                cut;
    thr_start = mon.throttle;
    r.drive_off = 1'b0;
    mon.alarm_bits = mon.alarm_bits & ~w.clear_mask;
    if (!(limits.alarm_enable == '0 && !mon.irq_level)) begin
      gap = int'(w.position) - int'(w.target);
      if (limits.alarm_enable[BitOverVolt]) begin
        if (limits.volt_max != '0 && w.voltage > limits.volt_max)
          mon.alarm_bits[BitOverVolt] = 1'b1;
        else if (limits.volt_min != '0 && w.voltage < limits.volt_min)
          mon.alarm_bits[BitUnderVolt] = 1'b1;
      end
      if (limits.alarm_enable[BitOverCurr] && limits.curr_max != '0 &&
          w.current > limits.curr_max) begin
        mon.alarm_bits[BitOverCurr] = 1'b1;
        mon.throttle = w.current - limits.curr_max;
      end
      if (limits.alarm_enable[BitOverTemp] && limits.temp_max != '0 &&
          w.temperature > limits.temp_max) begin
        mon.alarm_bits[BitOverTemp] = 1'b1;
        r.drive_off = 1'b1;
      end
      if (limits.alarm_enable[BitInPos] && gap >= -PosWindow && gap <= PosWindow) begin
        mon.alarm_bits[BitInPos] = 1'b1;
        mon.irq_level = 1'b1;
      end else begin
        mon.alarm_bits[BitInPos] = 1'b0;
      end
      if ((mon.alarm_bits & limits.irq_mask) == '0)
        mon.irq_level = 1'b0;
      if (mon.throttle != '0)
        mon.throttle = mon.throttle - 1'b1;
    end
    // pull the drive toward zero by twice the starting throttle, no overshoot
    lvl = int'($signed(w.drive_in));
    cut = 2 * int'(thr_start);
    if (lvl > 0) begin
      lvl = lvl - cut;
      if (lvl < 0) lvl = 0;
    end else if (lvl < 0) begin
      lvl = lvl + cut;
      if (lvl > 0) lvl = 0;
    end
    r.status    = mon.alarm_bits;
    r.irq_line  = mon.irq_level;
    r.drive_out = lvl[SampleW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    item_t w;
    res_t  got;
    res_t  want;
    if (rst) begin
      limits.volt_max     = '0;
      limits.volt_min     = '0;
      limits.temp_max     = '0;
      limits.curr_max     = '0;
      limits.alarm_enable = MaskAll;
      limits.irq_mask     = MaskAll;
      mon = '0;
      due_results.delete();
      err_cnt = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegVoltMax:     limits.volt_max = cfg_data;
          RegVoltMin:     limits.volt_min = cfg_data;
          RegTempMax:     limits.temp_max = cfg_data;
          RegCurrMax:     limits.curr_max = cfg_data;
          RegAlarmEnable: limits.alarm_enable = cfg_data[AlarmW-1:0];
          RegIrqMask:     limits.irq_mask = cfg_data[AlarmW-1:0];
          default: ;
        endcase
      end
      if (sample.valid && sample.ready) begin
        w.voltage     = sample.voltage;
        w.current     = sample.current;
        w.temperature = sample.temperature;
        w.position    = sample.position;
        w.target      = sample.target;
        w.drive_in    = sample.drive_in;
        w.clear_mask  = sample.clear_mask;
        due_results.push_back(next_alarm_result(w));
      end
      if (result.valid && result.ready) begin
        got.status    = result.status;
        got.irq_line  = result.irq_line;
        got.drive_out = result.drive_out;
        got.drive_off = result.drive_off;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, got);
          err_cnt++;
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %h got %h", $time, want.status, got.status);
            err_cnt++;
          end
          if (got.irq_line !== want.irq_line) begin
            $display("%0t: irq_line expected %b got %b", $time, want.irq_line, got.irq_line);
            err_cnt++;
          end
          if (got.drive_out !== want.drive_out) begin
            $display("%0t: drive_out expected %0d got %0d", $time, want.drive_out,
                     got.drive_out);
            err_cnt++;
          end
          if (got.drive_off !== want.drive_off) begin
            $display("%0t: drive_off expected %b got %b", $time, want.drive_off,
                     got.drive_off);
            err_cnt++;
          end
        end
      end
    end
    mismatches <= err_cnt;
    awaiting   <= due_results.size();
  end

endmodule

// File: tb/tb_limit_alarm_monitor.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the limit alarm monitor. The result checker beside
// the block predicts every result word and counts mismatches; this module only
// drives reset, sample words, configuration writes and result back-pressure.
module tb_limit_alarm_monitor;
  import lam_pkg::*;

  localparam int Phases         = 12;
  localparam int RandomPerPhase = 135;
  localparam int StallLimit     = 2000;  // cycles with no word moving
  localparam int DrainCycles    = 6;     // margin after the final drain

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                calm;   // no idling on either side
  int                  mismatch_count;
  int                  words_due;
  int                  stuck;

  lam_in_if  sample_ch ();
  lam_out_if result_ch ();

  limit_alarm_monitor DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  lam_result_checker u_result_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample     (sample_ch),
    .result     (result_ch),
    .mismatches (mismatch_count),
    .awaiting   (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run once nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || cfg_we || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= StallLimit) begin
      $display("tb_limit_alarm_monitor failed");
      $finish;
    end
  end

  // Result back-pressure: hold ready low in random bursts until the calm tail.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
    end
  end

  function automatic item_t mk(logic [SampleW-1:0] v, logic [SampleW-1:0] c,
                               logic [SampleW-1:0] t, logic [SampleW-1:0] p,
                               logic [SampleW-1:0] g, logic [SampleW-1:0] d,
                               logic [AlarmW-1:0] clr);
    item_t w;
    w.voltage     = v;
    w.current     = c;
    w.temperature = t;
    w.position    = p;
    w.target      = g;
    w.drive_in    = d;
    w.clear_mask  = clr;
    return w;
  endfunction

  // Pick a limit: disabled, extremes, tiny or anywhere.
  function automatic logic [SampleW-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 16'd1;
      3, 4:    return 16'($urandom);
      default: return 16'($urandom_range(1, 4000));
    endcase
  endfunction

  // Sample value that half the time lands within three counts of a limit.
  function automatic logic [SampleW-1:0] near(logic [SampleW-1:0] lim);
    case ($urandom_range(0, 5))
      0:       return 16'($urandom);
      1:       return '0;
      2:       return '1;
      default: return lim + 16'($urandom_range(0, 6)) - 16'd3;
    endcase
  endfunction

  function automatic cfg_t phase_setup(int style);
    cfg_t c;
    c.volt_max     = pick_limit();
    c.volt_min     = pick_limit();
    c.temp_max     = pick_limit();
    c.curr_max     = pick_limit();
    c.alarm_enable = AlarmW'($urandom_range(0, 31));
    c.irq_mask     = AlarmW'($urandom_range(0, 31));
    case (style)
      0: begin  // every limit disabled
        c.volt_max = '0; c.volt_min = '0; c.temp_max = '0; c.curr_max = '0;
        c.alarm_enable = MaskAll; c.irq_mask = MaskAll;
      end
      1: begin  // limits at full scale
        c.volt_max = '1; c.volt_min = '1; c.temp_max = '1; c.curr_max = '1;
        c.alarm_enable = MaskAll; c.irq_mask = MaskAll;
      end
      2: begin  // lowest live limits
        c.volt_max = 16'd1; c.volt_min = 16'd1; c.temp_max = 16'd1; c.curr_max = 16'd1;
      end
      3: c.alarm_enable = '0;
      4: begin
        c.alarm_enable = MaskAll;
        c.irq_mask = '0;
      end
      default: ;
    endcase
    return c;
  endfunction

  // Random sample word shaped around the programmed limits.
  function automatic item_t random_word(cfg_t c);
    item_t w;
    w.voltage     = $urandom_range(0, 1) ? near(c.volt_max) : near(c.volt_min);
    w.current     = near(c.curr_max);
    w.temperature = near(c.temp_max);
    w.target      = 16'($urandom);
    if ($urandom_range(0, 4) < 3)
      w.position = w.target + 16'($urandom_range(0, 8)) - 16'd4;
    else
      w.position = 16'($urandom);
    case ($urandom_range(0, 9))
      0:       w.drive_in = 16'h8000;
      1:       w.drive_in = 16'h7FFF;
      2:       w.drive_in = '0;
      3:       w.drive_in = '1;
      4:       w.drive_in = 16'd1;
      default: w.drive_in = 16'($urandom);
    endcase
    w.clear_mask = ($urandom_range(0, 3) == 0) ? AlarmW'($urandom_range(0, 31)) : '0;
    return w;
  endfunction

  // Drive one word and hold it until the block takes it. Valid stays high
  // afterwards so the next word can follow back to back.
  task automatic send_word(item_t w);
    if (!calm && $urandom_range(0, 5) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.voltage     <= w.voltage;
    sample_ch.current     <= w.current;
    sample_ch.temperature <= w.temperature;
    sample_ch.position    <= w.position;
    sample_ch.target      <= w.target;
    sample_ch.drive_in    <= w.drive_in;
    sample_ch.clear_mask  <= w.clear_mask;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // Drop valid and wait until every predicted result word has come back.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Program all six registers back to back; only call with the block idle.
  task automatic program_regs(cfg_t c);
    write_reg(RegVoltMax, c.volt_max);
    write_reg(RegVoltMin, c.volt_min);
    write_reg(RegTempMax, c.temp_max);
    write_reg(RegCurrMax, c.curr_max);
    write_reg(RegAlarmEnable, CfgDataW'(c.alarm_enable));
    write_reg(RegIrqMask, CfgDataW'(c.irq_mask));
    cfg_we <= 1'b0;
  endtask

  initial begin
    cfg_t setup;
    sample_ch.valid       <= 1'b0;
    sample_ch.voltage     <= '0;
    sample_ch.current     <= '0;
    sample_ch.temperature <= '0;
    sample_ch.position    <= '0;
    sample_ch.target      <= '0;
    sample_ch.drive_in    <= '0;
    sample_ch.clear_mask  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= RegVoltMax;
    cfg_data  <= '0;
    calm      <= 1'b0;
    rst       <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset limits: every range check off, only in-position can fire.
    send_word(mk(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, '0));
    send_word(mk('1, '1, '1, 16'd7, 16'd9, 16'h7FFF, '0));
    drain();

    setup.volt_max = 16'd1000;
    setup.volt_min = 16'd200;
    setup.temp_max = 16'd500;
    setup.curr_max = 16'd300;
    setup.alarm_enable = MaskAll;
    setup.irq_mask = MaskAll;
    program_regs(setup);
    // under-voltage at zero, everything at full scale, then exactly at limits
    send_word(mk(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, '0));
    send_word(mk('1, '1, '1, '1, 16'd0, 16'h7FFF, MaskAll));
    send_word(mk(16'd1000, 16'd300, 16'd500, 16'd0, '1, 16'h8000, '0));
    // one below the low limit, small over-current, window edge at minus two
    send_word(mk(16'd199, 16'd310, 16'd501, 16'd100, 16'd102, 16'd1000, MaskAll));
    // window edge at plus two; throttle eats a small drive of either sign
    send_word(mk(16'd200, 16'd0, 16'd0, 16'd102, 16'd100, 16'd5, 5'b00011));
    send_word(mk(16'd1001, 16'd0, 16'd0, 16'd103, 16'd100, -16'sd10, '0));
    send_word(mk(16'd500, 16'd0, 16'd0, 16'd97, 16'd100, 16'd100, '0));
    // clear everything, then re-arm in-position so the line goes high
    send_word(mk(16'd500, 16'd0, 16'd0, 16'd0, 16'd1, -16'sd100, MaskAll));
    send_word(mk(16'd500, 16'd0, 16'd0, 16'd5, 16'd5, 16'd1, 5'b10000));
    send_word(mk(16'd500, 16'd305, 16'd0, 16'd1, '1, '1, '0));
    drain();

    // All checks off while the line is still high: ticks are evaluated until
    // a full clear lowers the line, after which ticks are skipped.
    setup.alarm_enable = '0;
    program_regs(setup);
    send_word(mk('1, '1, '1, 16'd5, 16'd5, 16'd1000, '0));
    send_word(mk(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, -16'sd1000, MaskAll));
    send_word(mk('1, '1, '1, 16'd0, 16'd0, 16'd1000, '0));
    send_word(mk(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, -16'sd3, '0));
    drain();

    // In-position with an empty irq mask: raised and lowered in one tick.
    setup.alarm_enable = MaskAll;
    setup.irq_mask = '0;
    program_regs(setup);
    send_word(mk(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, '0));
    drain();

    // Random phases, each under a fresh setting; the tail runs with no idling.
    for (int p = 0; p < Phases; p++) begin
      setup = phase_setup(p);
      program_regs(setup);
      if (p == Phases - 1)
        calm <= 1'b1;
      for (int n = 0; n < RandomPerPhase; n++)
        send_word(random_word(setup));
      drain();
    end

    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && words_due == 0)
      $display("tb_limit_alarm_monitor passed");
    else
      $display("tb_limit_alarm_monitor failed");
    $finish;
  end

endmodule

// File: files.f
rtl/lam_pkg.sv
rtl/lam_if.sv
rtl/lam_cfg.sv
rtl/lam_check.sv
rtl/limit_alarm_monitor.sv
tb/lam_result_checker.sv
tb/tb_limit_alarm_monitor.sv
